// ===== hw/rtl/xysp_pkg.sv =====
// ----------------------------------------------------------------------------
// xysp_pkg
// Shared types and constants for the xy scope bitmap plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package xysp_pkg;

	// bitmap geometry: 256x256 pixels, 32 bytes per row
	localparam int BITMAP_AW    = 13;
	localparam int BITMAP_DEPTH = 1 << BITMAP_AW;
	localparam int BYTE_W       = 8;

	// frame counter wraps at a multiple of both refresh periods
	localparam int          FRAME_CNT_W = 4;
	localparam logic [3:0]  FRAME_LAST  = 4'd11;

	// item kinds as carried on the input user field
	localparam logic KIND_PLOT = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	// stream widths
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;

	// one classified item as handed from front to back
	typedef struct packed {
		logic                  is_read;
		logic                  frame_end;
		logic                  bank_sel;
		logic [BITMAP_AW-1:0]  addr;
		logic [BYTE_W-1:0]     mask;
	} entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xysp_front.sv =====
// ----------------------------------------------------------------------------
// xysp_front
// Accepts input beats, works out byte address and pixel mask, and registers
// the classified item for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module xysp_front import xysp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  init_busy,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [15:0] sample_left, [31:16] sample_right, [32] read_buffer,
	// [45:33] read_address, [47:46] zero
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// [0] kind
	input  wire logic                  s_tuser,
	// frame_end
	input  wire logic                  s_tlast,
	output logic                       q_valid,
	input  wire logic                  q_ready,
	output entry_t                     q_entry
);

	logic   valid_s1;
	entry_t entry_s1;
	entry_t entry_next;
	logic [7:0] col;
	logic [7:0] row;
	logic s_accept;

	// pixel position: signed high byte offset to unsigned screen coordinates
	always_comb begin
		col = s_tdata[15:8] ^ 8'h80;
		row = s_tdata[31:24] ^ 8'h7f;
		entry_next.is_read   = (s_tuser == KIND_READ);
		entry_next.frame_end = s_tlast;
		entry_next.bank_sel  = s_tdata[32];
		if (s_tuser == KIND_READ) begin
			entry_next.addr = s_tdata[45:33];
			entry_next.mask = '0;
		end else begin
			entry_next.addr = {row, col[7:3]};
			entry_next.mask = 8'h80 >> col[2:0];
		end
	end

	assign s_tready = !init_busy && (!valid_s1 || q_ready);
	assign s_accept = s_tvalid && s_tready;

	// stage register towards the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			entry_s1 <= entry_next;
		end
	end

	assign q_valid = valid_s1;
	assign q_entry = entry_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/xysp_queue.sv =====
// ----------------------------------------------------------------------------
// xysp_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module xysp_queue import xysp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  entry_t      in_entry,
	output logic        out_valid,
	input  wire logic   out_ready,
	output entry_t      out_entry
);

	entry_t slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic push;
	logic pop;

	assign in_ready  = (count_q != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_entry = slots_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= in_entry;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/xysp_back.sv =====
// ----------------------------------------------------------------------------
// xysp_back
// Executes items on the two bitmap memories: pixel read-modify-write, byte
// reads, frame counting, buffer clear sweeps and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xysp_back import xysp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic                  cfg_wr_data,
	output logic                       init_busy,
	input  wire logic                  q_valid,
	output logic                       q_ready,
	input  entry_t                     q_entry,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [0] show_now, [1] shown_buffer, [9:2] read_data, [15:10] zero
	output logic [M_TDATA_W-1:0]       m_tdata
);

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	logic [1:0] state_q;
	logic [BITMAP_AW-1:0] sweep_q;
	logic clear_bank_q;
	entry_t item_q;
	logic high_rate_q;
	logic [FRAME_CNT_W-1:0] frame_cnt_q;
	logic toggle_q;

	logic out_valid_q;
	logic out_show_q;
	logic out_shown_q;
	logic [BYTE_W-1:0] out_data_q;

	logic [BYTE_W-1:0] bitmap_first  [BITMAP_DEPTH];
	logic [BYTE_W-1:0] bitmap_second [BITMAP_DEPTH];
	logic [BYTE_W-1:0] rdata_first_q;
	logic [BYTE_W-1:0] rdata_second_q;

	logic [BITMAP_AW-1:0] mem_addr;
	logic we_first;
	logic we_second;
	logic [BYTE_W-1:0] wdata_first;
	logic [BYTE_W-1:0] wdata_second;

	logic pop;
	logic is_plot_end;
	logic [FRAME_CNT_W-1:0] frame_next;
	logic do_show;
	logic do_clear;
	logic sweep_done;

	assign init_busy  = (state_q == ST_INIT);
	assign pop        = (state_q == ST_IDLE) && q_valid && (!out_valid_q || m_tready);
	assign q_ready    = pop;
	assign sweep_done = (sweep_q == '1);

	// frame counter step and refresh phase
	always_comb begin
		is_plot_end = (state_q == ST_EXEC) && !item_q.is_read && item_q.frame_end;
		frame_next  = (frame_cnt_q == FRAME_LAST) ? '0 : frame_cnt_q + 1'b1;
		if (high_rate_q) begin
			do_show  = (frame_next[1:0] == 2'd0);
			do_clear = (frame_next[1:0] == 2'd1);
		end else begin
			do_show  = (frame_next == 4'd0) || (frame_next == 4'd6);
			do_clear = (frame_next == 4'd2) || (frame_next == 4'd8);
		end
	end

	// memory port control
	always_comb begin
		mem_addr     = item_q.addr;
		we_first     = 1'b0;
		we_second    = 1'b0;
		wdata_first  = '0;
		wdata_second = '0;
		case (state_q)
			ST_INIT: begin
				mem_addr  = sweep_q;
				we_first  = 1'b1;
				we_second = 1'b1;
			end
			ST_IDLE: begin
				mem_addr = q_entry.addr;
			end
			ST_EXEC: begin
				we_first     = !item_q.is_read;
				we_second    = !item_q.is_read;
				wdata_first  = rdata_first_q | item_q.mask;
				wdata_second = rdata_second_q | item_q.mask;
			end
			ST_CLEAR: begin
				mem_addr  = sweep_q;
				we_first  = !clear_bank_q;
				we_second = clear_bank_q;
			end
			default: begin
				mem_addr = item_q.addr;
			end
		endcase
	end

	// first bitmap, single port, read first
	always_ff @(posedge clk) begin
		if (we_first) begin
			bitmap_first[mem_addr] <= wdata_first;
		end
		rdata_first_q <= bitmap_first[mem_addr];
	end

	// second bitmap, single port, read first
	always_ff @(posedge clk) begin
		if (we_second) begin
			bitmap_second[mem_addr] <= wdata_second;
		end
		rdata_second_q <= bitmap_second[mem_addr];
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_rate_q <= 1'b0;
		end else if (cfg_wr_en) begin
			high_rate_q <= cfg_wr_data;
		end
	end

	// sequencer, frame counter and display toggle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			sweep_q      <= '0;
			clear_bank_q <= 1'b0;
			frame_cnt_q  <= '0;
			toggle_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (is_plot_end) begin
						frame_cnt_q <= frame_next;
						if (!do_show && do_clear) begin
							clear_bank_q <= toggle_q;
							toggle_q     <= !toggle_q;
							sweep_q      <= '0;
							state_q      <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// latched item under execution
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_entry;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EXEC) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			out_show_q  <= is_plot_end && do_show;
			out_shown_q <= is_plot_end && do_show && toggle_q;
			if (item_q.is_read) begin
				out_data_q <= item_q.bank_sel ? rdata_second_q : rdata_first_q;
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_data_q, out_shown_q, out_show_q};

endmodule

`default_nettype wire

// ===== hw/rtl/xy_scope_bitmap_plotter_top.sv =====
// ----------------------------------------------------------------------------
// xy_scope_bitmap_plotter_top
// Plots stereo samples into two 256x256 one-bit bitmaps, paces the display
// refresh from frame ends and serves byte reads of either bitmap.
// ----------------------------------------------------------------------------
// usage
//   input beats on s_*: tuser is the kind (plot or read), tlast the frame end
//   flag, tdata the samples and the read address; one result beat on m_* for
//   every input beat, in order, carrying show strobe, buffer and read byte
//   the back end handles each item as a read-modify-write of the single-port
//   bitmap memories (read, then write back) and takes no new item meanwhile
//   a result beat passes the front stage, the queue and the back end read and
//   write before it is offered
//   a frame end that clears a buffer sweeps it one byte a cycle, during which
//   the two-entry queue and front stage still take beats
//   reset: after arst_n rises both bitmaps are swept to zero with s_tready low;
//   configuration writes are taken throughout
//   a stalled receiver holds the result register; the back end waits and the
//   queue and front stage fill before s_tready drops
//   cfg_wr_en/cfg_wr_data write high_rate_mode (four-frame refresh when set)
// ----------------------------------------------------------------------------
`default_nettype none

module xy_scope_bitmap_plotter_top import xysp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic                  cfg_wr_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [15:0] sample_left, [31:16] sample_right, [32] read_buffer,
	// [45:33] read_address, [47:46] zero
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// [0] kind
	input  wire logic                  s_tuser,
	// frame_end
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [0] show_now, [1] shown_buffer, [9:2] read_data, [15:10] zero
	output logic [M_TDATA_W-1:0]       m_tdata
);

	logic   init_busy;
	logic   fq_valid;
	logic   fq_ready;
	entry_t fq_entry;
	logic   qb_valid;
	logic   qb_ready;
	entry_t qb_entry;

	// front: accept and classify
	xysp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.init_busy (init_busy),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_entry   (fq_entry)
	);

	// decoupling queue
	xysp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_entry  (fq_entry),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_entry (qb_entry)
	);

	// back: memories, frame pacing and results
	xysp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.init_busy   (init_busy),
		.q_valid     (qb_valid),
		.q_ready     (qb_ready),
		.q_entry     (qb_entry),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

`default_nettype wire
